[src/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY_DEFAULT     = 16;
    localparam int KEY_BITS_DEFAULT     = 64;
    localparam int PAYLOAD_BITS_DEFAULT = 32;
    localparam int ENTRY_COUNT_BITS     = 5;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } spq_op_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } spq_status_t;

    // Strobes broadcast to every cell of the chain for one word.
    typedef struct packed {
        logic enq;
        logic deq;
    } spq_ctrl_t;

endpackage

[src/sorted_insert_priority_queue.sv]
`timescale 1ns / 1ps

// Bounded priority queue held as a chain of CAPACITY cells in ascending key
// order, cell 0 holding the smallest key. Every cell compares its key with the
// incoming key at once and then keeps its entry, loads the new one, or takes
// its neighbor's, so an enqueue or a dequeue updates all cells together and one
// word is accepted per clock while the result register is drained. A new entry
// goes in front of equal keys. Each word returns one result with a status
// (enqueued, dequeued, empty or full) and the count held afterwards;
// out_key and out_payload are zero unless the status is dequeued.

module sorted_insert_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEFAULT,
    parameter int KEY_BITS     = KEY_BITS_DEFAULT,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [KEY_BITS-1:0]         item_key,
    input  logic [PAYLOAD_BITS-1:0]     item_payload,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [KEY_BITS-1:0]         out_key,
    output logic [PAYLOAD_BITS-1:0]     out_payload,
    output logic [ENTRY_COUNT_BITS-1:0] entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                    accept;
    logic                    full;
    logic                    empty;
    spq_ctrl_t               ctrl;
    spq_status_t             status_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    out_valid_reg;
    spq_status_t             status_reg;
    logic [KEY_BITS-1:0]     out_key_reg;
    logic [PAYLOAD_BITS-1:0] out_payload_reg;

    logic                    ge_w      [CAPACITY];
    logic [KEY_BITS-1:0]     key_w     [CAPACITY];
    logic [PAYLOAD_BITS-1:0] payload_w [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = ST_EMPTY;
        if (spq_op_t'(operation) == OP_ENQUEUE)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_ENQUEUED;
                ctrl.enq    = accept;
                if (accept)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_DEQUEUED;
                ctrl.deq    = accept;
                if (accept)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                    left_ge;
        logic [KEY_BITS-1:0]     left_key;
        logic [PAYLOAD_BITS-1:0] left_payload;
        logic [KEY_BITS-1:0]     right_key;
        logic [PAYLOAD_BITS-1:0] right_payload;

        if (i == 0)
        begin : g_head
            assign left_ge      = 1'b0;
            assign left_key     = item_key;
            assign left_payload = item_payload;
        end
        else
        begin : g_body
            assign left_ge      = ge_w[i-1];
            assign left_key     = key_w[i-1];
            assign left_payload = payload_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_key     = '0;
            assign right_payload = '0;
        end
        else
        begin : g_link
            assign right_key     = key_w[i+1];
            assign right_payload = payload_w[i+1];
        end

        spq_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .clk           (clk),
            .ctrl          (ctrl),
            .occupied      (CNT_W'(i) < count_reg),
            .new_key       (item_key),
            .new_payload   (item_payload),
            .left_ge       (left_ge),
            .left_key      (left_key),
            .left_payload  (left_payload),
            .right_key     (right_key),
            .right_payload (right_payload),
            .ge            (ge_w[i]),
            .key           (key_w[i]),
            .payload       (payload_w[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            if (status_next == ST_DEQUEUED)
            begin
                out_key_reg     <= key_w[0];
                out_payload_reg <= payload_w[0];
            end
            else
            begin
                out_key_reg     <= '0;
                out_payload_reg <= '0;
            end
        end
    end

    // The count register already holds the count after the word in flight.
    logic [CNT_W-1:0] result_count_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_count_reg <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_payload_reg;
    assign entry_count = ENTRY_COUNT_BITS'(result_count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (key_w[0] <= key_w[1]))
        else $error("head cells out of order");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !full && spq_op_t'(operation) == OP_ENQUEUE)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("enqueue did not raise the count");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && empty && spq_op_t'(operation) == OP_DEQUEUE)
        |=> (status_reg == ST_EMPTY && count_reg == '0))
        else $error("dequeue on empty queue misreported");

endmodule

[src/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
#(
    parameter int KEY_BITS     = KEY_BITS_DEFAULT,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  spq_ctrl_t               ctrl,
    input  logic                    occupied,
    input  logic [KEY_BITS-1:0]     new_key,
    input  logic [PAYLOAD_BITS-1:0] new_payload,
    input  logic                    left_ge,
    input  logic [KEY_BITS-1:0]     left_key,
    input  logic [PAYLOAD_BITS-1:0] left_payload,
    input  logic [KEY_BITS-1:0]     right_key,
    input  logic [PAYLOAD_BITS-1:0] right_payload,
    output logic                    ge,
    output logic [KEY_BITS-1:0]     key,
    output logic [PAYLOAD_BITS-1:0] payload
);

    logic [KEY_BITS-1:0]     key_reg;
    logic [KEY_BITS-1:0]     key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;

    // An empty cell counts as "greater or equal", so the flags along the
    // chain form a run of zeros followed by a run of ones.
    assign ge = !occupied || (key_reg >= new_key);

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctrl.deq)
        begin
            key_next     = right_key;
            payload_next = right_payload;
        end
        else if (ctrl.enq && ge)
        begin
            if (!left_ge)
            begin
                key_next     = new_key;
                payload_next = new_payload;
            end
            else
            begin
                key_next     = left_key;
                payload_next = left_payload;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;

endmodule
